// ===== src/rlms_pkg.sv =====
// Shared constants and types for the RGB LED matrix row scanner.
package rlms_pkg;

  // Request field widths
  localparam int CMD_W   = 1;
  localparam int X_W     = 6;
  localparam int Y_W     = 4;
  localparam int COMP_W  = 8;
  localparam int S_DATA_W = 40;   // x, y, r, g, b = 34 bits, padded to bytes

  // Result field widths
  localparam int BITS_W   = 6;
  localparam int SEL_W    = 3;
  localparam int M_DATA_W = 16;   // color_bits, row_select = 9 bits, padded

  // Configuration register widths
  localparam int AWIDTH_W = 7;
  localparam int ROWS_W   = 4;
  localparam int LEVELS_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Width of a column count that can hold the largest panel width
  localparam int CNT_W = 9;
  // Lower row number before the range check
  localparam int DROW_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 2'd0,
    CFG_ROWS_PER_HALF = 2'd1,
    CFG_COLOR_LEVELS  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 1'b0,
    CMD_SCAN  = 1'b1
  } cmd_t;

endpackage

// ===== src/rgb_led_matrix_row_scanner.sv =====
// Row scanner: frame store, per-column intensity compare and row/level counters.
// A pixel write request goes into the frame store in the cycle it is accepted.
// A row tick is registered, then columns pass through the read stage and result
// register at one column per cycle while m_tready stays high; s_tready stays low
// until the single shared store read / compare path has walked every column pair.
// Reset: synchronous; counters clear, then a clearing pass zeroes all MAX_WIDTH *
// MAX_ROWS frame store words while s_tready stays low.
module rgb_led_matrix_row_scanner #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_ROWS   = 16,
  parameter int COLOR_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // Requests
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rlms_pkg::S_DATA_W-1:0]  s_tdata,  // pix_x, pix_y, red, green, blue
  input  logic [rlms_pkg::CMD_W-1:0]     s_tuser,  // cmd
  // Results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rlms_pkg::M_DATA_W-1:0]  m_tdata,  // color_bits, row_select
  output logic                           m_tlast,  // last
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlms_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlms_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCW    = $clog2(MAX_WIDTH + 1);
  localparam int WORD_W = 3 * COLOR_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Request fields
  logic [CMD_W-1:0]  req_cmd;
  logic [X_W-1:0]    req_x;
  logic [Y_W-1:0]    req_y;
  logic [COMP_W-1:0] req_r, req_g, req_b;

  assign req_cmd = s_tuser;
  assign req_x   = s_tdata[5:0];
  assign req_y   = s_tdata[9:6];
  assign req_r   = s_tdata[17:10];
  assign req_g   = s_tdata[25:18];
  assign req_b   = s_tdata[33:26];

  // Control and configuration registers
  state_t               state;
  logic [AW-1:0]        clr_addr;
  logic [AWIDTH_W-1:0]  active_width;
  logic [ROWS_W-1:0]    rows_per_half;
  logic [LEVELS_W-1:0]  color_levels;
  logic [SEL_W-1:0]     scan_row;
  logic [LEVELS_W-1:0]  level_count;

  // Per-tick scan registers
  logic [LEVELS_W-1:0]  scan_level;
  logic [SEL_W-1:0]     scan_sel;
  logic [AW-1:0]        up_base, dn_base;
  logic                 up_ok, dn_ok;
  logic [XW-1:0]        col;
  logic [WCW-1:0]       issue_left;

  // Read stage
  logic                 s1_valid;
  logic                 s1_last;
  logic [WORD_W-1:0]    up_q, dn_q;

  // Frame store
  logic [WORD_W-1:0]    frame_mem [DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  logic                 req_fire;
  logic                 out_free;
  logic                 s1_load;
  logic                 rd_en;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign req_fire  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign s1_load   = !s1_valid || out_free;
  assign rd_en     = (state == ST_SCAN) && (issue_left != '0) && s1_load;

  // Pixel write address and range check
  logic          pix_ok;
  logic [AW-1:0] pix_addr;

  assign pix_ok   = ({3'b000, req_x} < CNT_W'(MAX_WIDTH)) &&
                    ({1'b0, req_y} < DROW_W'(MAX_ROWS));
  assign pix_addr = AW'(req_y) * AW'(MAX_WIDTH) + AW'(req_x);

  // Tick set-up: clamped width, row bases and counter advance
  logic [CNT_W-1:0]    width_clamp;
  logic [DROW_W-1:0]   dn_row;
  logic [LEVELS_W:0]   level_inc;
  logic [SEL_W-1:0]    row_inc;
  logic [LEVELS_W-1:0] level_next;
  logic [SEL_W-1:0]    scan_row_next;

  always_comb begin
    if ({2'b00, active_width} > CNT_W'(MAX_WIDTH)) begin
      width_clamp = CNT_W'(MAX_WIDTH);
    end else begin
      width_clamp = {2'b00, active_width};
    end
    dn_row    = {2'b00, scan_row} + {1'b0, rows_per_half};
    level_inc = {1'b0, level_count} + 1'b1;
    row_inc   = scan_row + 1'b1;
    if (level_inc >= {1'b0, color_levels}) begin
      level_next = '0;
      if ({1'b0, row_inc} >= rows_per_half) begin
        scan_row_next = '0;
      end else begin
        scan_row_next = row_inc;
      end
    end else begin
      level_next    = level_inc[LEVELS_W-1:0];
      scan_row_next = scan_row;
    end
  end

  // Store write port: clearing pass or pixel write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (req_fire && (req_cmd == CMD_WRITE) && pix_ok) begin
      mem_we    = 1'b1;
      mem_waddr = pix_addr;
      mem_wdata = {req_b[COLOR_BITS-1:0], req_g[COLOR_BITS-1:0], req_r[COLOR_BITS-1:0]};
    end
  end

  // Frame store memory, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      up_q <= frame_mem[up_base + AW'(col)];
      dn_q <= frame_mem[dn_base + AW'(col)];
    end
  end

  // Shared compare unit: one column pair against the level
  logic [WORD_W-1:0] up_px, dn_px;
  logic [BITS_W-1:0] col_bits;

  always_comb begin
    up_px = up_ok ? up_q : '0;
    dn_px = dn_ok ? dn_q : '0;
    for (int c = 0; c < 3; c++) begin
      col_bits[c]     = COMP_W'(up_px[c*COLOR_BITS +: COLOR_BITS]) > scan_level;
      col_bits[c + 3] = COMP_W'(dn_px[c*COLOR_BITS +: COLOR_BITS]) > scan_level;
    end
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      active_width  <= AWIDTH_W'(64);
      rows_per_half <= ROWS_W'(8);
      color_levels  <= LEVELS_W'(16);
      scan_row      <= '0;
      level_count   <= '0;
      issue_left    <= '0;
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ACTIVE_WIDTH:  active_width  <= cfg_data[AWIDTH_W-1:0];
          CFG_ROWS_PER_HALF: rows_per_half <= cfg_data[ROWS_W-1:0];
          CFG_COLOR_LEVELS:  color_levels  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire && (req_cmd == CMD_SCAN)) begin
            scan_level  <= level_count;
            scan_sel    <= ~scan_row;
            up_ok       <= {2'b00, scan_row} < DROW_W'(MAX_ROWS);
            dn_ok       <= dn_row < DROW_W'(MAX_ROWS);
            up_base     <= AW'(scan_row) * AW'(MAX_WIDTH);
            dn_base     <= AW'(dn_row[3:0]) * AW'(MAX_WIDTH);
            issue_left  <= width_clamp[WCW-1:0];
            col         <= XW'(width_clamp - 1'b1);
            level_count <= level_next;
            scan_row    <= scan_row_next;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_left <= issue_left - 1'b1;
            col        <= col - 1'b1;
          end
          if ((issue_left == '0) && !s1_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // read stage valid
      if (rd_en) begin
        s1_valid <= 1'b1;
        s1_last  <= (issue_left == WCW'(1));
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end

      // result register
      if (out_free) begin
        m_tvalid <= s1_valid;
        if (s1_valid) begin
          m_tdata <= {{(M_DATA_W - BITS_W - SEL_W){1'b0}}, scan_sel, col_bits};
          m_tlast <= s1_last;
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the RGB LED matrix row scanner.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rlms_pkg::*;

  localparam int PANEL_W     = 64;
  localparam int PANEL_ROWS  = 16;
  localparam int SETTLE_GAP  = PANEL_W + 8;
  localparam int CYCLE_LIMIT = 800_000;

  typedef struct packed {
    logic [BITS_W-1:0] color_bits;
    logic [SEL_W-1:0]  row_select;
    logic              last;
  } column_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = CMD_WRITE;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ACTIVE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the block state
  logic [23:0]       pixel_mirror [PANEL_W*PANEL_ROWS];
  logic [2:0]        panel_row = '0;
  logic [8:0]        pwm_level = '0;
  logic [AWIDTH_W-1:0] cfg_width = 7'd64;
  logic [ROWS_W-1:0]   cfg_rows = 4'd8;
  logic [LEVELS_W-1:0] cfg_levels = 8'd16;

  column_t     pending_columns [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  logic [7:0]  ready_phase = '0;

  rgb_led_matrix_row_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // pix_x, pix_y, red, green, blue
    .s_tuser   (s_tuser),   // cmd
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // color_bits, row_select
    .m_tlast   (m_tlast),   // last
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d columns still pending", $time, pending_columns.size());
      $display("rgb_led_matrix_row_scanner verification failed");
      $finish;
    end
  end

  // Receiver backpressure, mode reshuffled each time the 8-bit phase counter wraps
  always @(negedge clk) begin
    ready_phase <= ready_phase + 8'd1;
    if (ready_phase == 8'hff)
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS:   m_tready <= 1'b1;
      READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
      default:        m_tready <= (ready_phase[2:0] != 3'd5);
    endcase
  end

  // Column result checker
  always @(posedge clk) begin : check_columns
    column_t want;
    if (m_tvalid && m_tready) begin
      if (pending_columns.size() == 0) begin
        error_count++;
        $display("%0t: unexpected column: expected none, got bits %h sel %h last %b",
                 $time, m_tdata[5:0], m_tdata[8:6], m_tlast);
      end else begin
        want = pending_columns.pop_front();
        if (m_tdata[5:0] !== want.color_bits || m_tdata[8:6] !== want.row_select ||
            m_tlast !== want.last) begin
          error_count++;
          $display({"%0t: column mismatch: expected bits %h sel %h last %b, ",
                    "got bits %h sel %h last %b"},
                   $time, want.color_bits, want.row_select, want.last,
                   m_tdata[5:0], m_tdata[8:6], m_tlast);
        end
      end
    end
  end

  function automatic logic [23:0] stored_pixel(logic [4:0] row, int col);
    if (row >= PANEL_ROWS)
      return '0;
    return pixel_mirror[int'(row) * PANEL_W + col];
  endfunction

  // One bit per component that is brighter than the current PWM level
  function automatic logic [2:0] lit_bits(logic [23:0] px);
    return {9'(px[23:16]) > pwm_level, 9'(px[15:8]) > pwm_level, 9'(px[7:0]) > pwm_level};
  endfunction

  // Expected columns of one row tick, rightmost first, then counter update
  function automatic void shift_out_row();
    int         cols;
    logic [4:0] lower_row;
    column_t    col_res;
    cols = (cfg_width > PANEL_W) ? PANEL_W : int'(cfg_width);
    lower_row = 5'(panel_row) + 5'(cfg_rows);
    for (int col = cols - 1; col >= 0; col--) begin
      col_res.color_bits = {lit_bits(stored_pixel(lower_row, col)),
                            lit_bits(stored_pixel(5'(panel_row), col))};
      col_res.row_select = ~panel_row;
      col_res.last = (col == 0);
      pending_columns.push_back(col_res);
    end
    pwm_level = pwm_level + 9'd1;
    if (pwm_level >= 9'(cfg_levels)) begin
      pwm_level = '0;
      panel_row = panel_row + 3'd1;
      if (4'(panel_row) >= cfg_rows)
        panel_row = '0;
    end
  endfunction

  // Drive one request, predict on acceptance, then pace the burst
  task automatic send_request(cmd_t op, logic [5:0] x, logic [3:0] y,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, b, g, r, y, x};
    do @(posedge clk); while (!s_tready);
    if (op == CMD_WRITE)
      pixel_mirror[int'(y) * PANEL_W + int'(x)] = {b, g, r};
    else
      shift_out_row();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic stop_requests();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_columns.size() != 0) @(posedge clk);
  endtask

  // Quiet the block before a register write
  task automatic settle_block();
    stop_requests();
    wait_drained();
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ACTIVE_WIDTH:  cfg_width = value[AWIDTH_W-1:0];
      CFG_ROWS_PER_HALF: cfg_rows = value[ROWS_W-1:0];
      CFG_COLOR_LEVELS:  cfg_levels = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [7:0] width, logic [7:0] rows, logic [7:0] levels);
    settle_block();
    write_register(CFG_ACTIVE_WIDTH, width);
    write_register(CFG_ROWS_PER_HALF, rows);
    write_register(CFG_COLOR_LEVELS, levels);
  endtask

  task automatic scan_row();
    send_request(CMD_SCAN, 6'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
  endtask

  // Intensity either anywhere or close to the level range in use
  function automatic logic [7:0] pick_intensity();
    if ($urandom_range(0, 1))
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, int'(cfg_levels) + 1));
  endfunction

  // Blank frame after the clearing pass, default registers
  task automatic test_blank_after_reset();
    scan_row();
  endtask

  // Corner, edge and middle pixels with component values 0, 1, 2 and 255
  task automatic test_corner_pixels();
    send_request(CMD_WRITE, 6'd0,  4'd0,  8'd255, 8'd0,   8'd1);
    send_request(CMD_WRITE, 6'd63, 4'd15, 8'd0,   8'd255, 8'd1);
    send_request(CMD_WRITE, 6'd63, 4'd1,  8'd1,   8'd2,   8'd255);
    send_request(CMD_WRITE, 6'd0,  4'd9,  8'd2,   8'd1,   8'd0);
    send_request(CMD_WRITE, 6'd31, 4'd8,  8'd255, 8'd255, 8'd255);
    scan_row();
    scan_row();
  endtask

  // Width one, width zero (no columns) and width clamped to the panel
  task automatic test_width_limits();
    settle_block();
    write_register(CFG_ACTIVE_WIDTH, 8'd1);
    scan_row();
    settle_block();
    write_register(CFG_ACTIVE_WIDTH, 8'd0);
    scan_row();
    settle_block();
    write_register(CFG_ACTIVE_WIDTH, 8'd127);
    scan_row();
  endtask

  // Row and level wrap corner cases, limits lowered mid scan
  task automatic test_row_level_limits();
    configure(8'd8, 8'd0, 8'd0);
    scan_row();
    scan_row();
    configure(8'd64, 8'd15, 8'd1);
    write_register(CFG_UNUSED, 8'hff);
    send_request(CMD_WRITE, 6'd5, 4'd15, 8'd200, 8'd0, 8'd9);
    scan_row();
    scan_row();
    scan_row();
    settle_block();
    write_register(CFG_COLOR_LEVELS, 8'd8);
    scan_row();
    scan_row();
    scan_row();
    settle_block();
    write_register(CFG_COLOR_LEVELS, 8'd2);
    scan_row();
  endtask

  // Random pixel writes and row ticks under one register setting
  task automatic test_random_traffic(logic [7:0] width, logic [7:0] rows,
                                     logic [7:0] levels, int count);
    logic [5:0] x;
    int         span;
    configure(width, rows, levels);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 29) == 0) begin
        stop_requests();
        wait_drained();
      end
      if ($urandom_range(0, 9) < 6) begin
        span = (cfg_width == 0) ? PANEL_W : ((cfg_width > PANEL_W) ? PANEL_W : int'(cfg_width));
        x = $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, span - 1));
        send_request(CMD_WRITE, x, 4'($urandom), pick_intensity(), pick_intensity(),
                     pick_intensity());
      end else begin
        scan_row();
      end
    end
  endtask

  initial begin
    foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_blank_after_reset();
    test_corner_pixels();
    test_width_limits();
    test_row_level_limits();
    test_random_traffic(8'd64,  8'd8,  8'd16,  34);
    test_random_traffic(8'd5,   8'd3,  8'd2,   34);
    test_random_traffic(8'd127, 8'd15, 8'd0,   34);
    test_random_traffic(8'd1,   8'd0,  8'd255, 34);
    test_random_traffic(8'd33,  8'd9,  8'd1,   34);
    test_random_traffic(8'd64,  8'd8,  8'd4,   34);
    test_random_traffic(8'd17,  8'd1,  8'd3,   34);

    settle_block();
    if (error_count == 0)
      $display("rgb_led_matrix_row_scanner verification clean");
    else
      $display("rgb_led_matrix_row_scanner verification failed");
    $finish;
  end

endmodule
